>>> hw/rtl/ktsr_pkg.sv
// ----------------------------------------------------------------------------
// ktsr_pkg: shared types and constants of the keyed table
// Holds the table depth, derived widths, payload structs, operation and
// status codes, and the token that walks the cell row.
// ----------------------------------------------------------------------------
package ktsr_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 32;
  localparam int REPS_W      = 16;
  localparam int TOTAL_W     = 23;
  localparam int SLOT_W      = 6;
  localparam int ECOUNT_W    = 7;
  localparam int TREPS_W     = 22;

  typedef enum logic [1:0] {
    MODE_ADD    = 2'd0,
    MODE_FIND   = 2'd1,
    MODE_REMOVE = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_MISSING = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_SCAN = 1'b1
  } state_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [KEY_W-1:0]  key;
    logic [REPS_W-1:0]        reps;
  } ktsr_in_t;

  typedef struct packed {
    status_t                  status;
    logic [SLOT_W-1:0]        slot;
    logic [REPS_W-1:0]        found_reps;
    logic [ECOUNT_W-1:0]      entry_count;
    logic [TREPS_W-1:0]       total_reps;
  } ktsr_out_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                     valid;
    logic signed [KEY_W-1:0]  key;
    logic                     found;
    logic [IDX_W-1:0]         hit_idx;
    logic [REPS_W-1:0]        hit_reps;
    logic signed [KEY_W-1:0]  last_key;
    logic [REPS_W-1:0]        last_reps;
  } tok_t;

  // Write broadcast to the row; only the addressed cell takes it.
  typedef struct packed {
    logic                     en;
    logic [IDX_W-1:0]         idx;
    logic signed [KEY_W-1:0]  key;
    logic [REPS_W-1:0]        reps;
  } wr_t;

  function automatic logic [SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] i);
    logic [IDX_W+SLOT_W-1:0] w;
    w = {{SLOT_W{1'b0}}, i};
    return w[SLOT_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] idx_to_cnt(input logic [IDX_W-1:0] i);
    logic [IDX_W+CNT_W-1:0] w;
    w = {{CNT_W{1'b0}}, i};
    return w[CNT_W-1:0];
  endfunction

  function automatic logic [ECOUNT_W-1:0] cnt_to_ecount(input logic [CNT_W-1:0] c);
    logic [CNT_W+ECOUNT_W-1:0] w;
    w = {{ECOUNT_W{1'b0}}, c};
    return w[ECOUNT_W-1:0];
  endfunction

endpackage

>>> hw/rtl/keyed_table_swap_remove_unit.sv
// ----------------------------------------------------------------------------
// keyed_table_swap_remove_unit: packed key/count table with swap-remove
// Add appends, find returns the lowest matching slot, remove moves the last
// entry into the first matching slot, clear empties the table.
//
//   channel | ports                          | moves
//   --------+--------------------------------+-------------------------------
//   input   | in_valid, in_stall, in_data    | one operation per transfer
//   output  | out_valid, out_stall, out_data | one result per operation
//
// Add and clear: result offered in the cycle after the input transfer.
// Find and remove: the result is offered once the search token has walked
//   the row one cell per cycle; no new transfer meanwhile.
// Reset clears the entry count, running total, state and output valid; the
//   stored keys and counts keep their values and are never read past the count.
// in_stall rises during a search and while a stalled result holds the output.
// ----------------------------------------------------------------------------
module keyed_table_swap_remove_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ktsr_pkg::ktsr_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ktsr_pkg::ktsr_out_t out_data
);
  import ktsr_pkg::*;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [TOTAL_W-1:0]  total_r, total_nxt;
  mode_t               mode_r;
  logic                out_valid_r, out_valid_nxt;
  ktsr_out_t           out_data_r;
  ktsr_out_t           res;
  logic                load_out;
  logic                in_accept;
  logic [CNT_W-1:0]    last_idx;
  wr_t                 wr;
  tok_t                chain [0:TABLE_DEPTH];
  tok_t                tail;

  assign last_idx  = used_r - 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign tail      = chain[TABLE_DEPTH];

  // Launch a search token into the first cell on a find or remove transfer.
  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = in_accept &&
                         ((in_data.mode == MODE_FIND) || (in_data.mode == MODE_REMOVE));
    chain[0].key       = in_data.key;
  end

  // The cell row: each cell owns one slot and forwards the token.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    ktsr_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (IDX_W'(g)),
      .used     (used_r),
      .last     (last_idx),
      .wr       (wr),
      .tok_in   (chain[g]),
      .tok_out  (chain[g+1])
    );
  end

  always_comb begin
    state_nxt = state_r;
    used_nxt  = used_r;
    total_nxt = total_r;
    wr        = '0;
    res       = '0;
    load_out  = 1'b0;
    // accept only when idle and the output slot frees up this cycle
    in_stall  = !((state_r == ST_IDLE) && (!out_valid_r || !out_stall));

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_data.mode)
            MODE_ADD: begin
              load_out = 1'b1;
              if (used_r == DEPTH_CNT) begin
                res.status = STAT_FULL;
              end else begin
                res.status = STAT_OK;
                res.slot   = idx_to_slot(used_r[IDX_W-1:0]);
                wr.en      = 1'b1;
                wr.idx     = used_r[IDX_W-1:0];
                wr.key     = in_data.key;
                wr.reps    = in_data.reps;
                used_nxt   = used_r + 1'b1;
                total_nxt  = total_r + TOTAL_W'(in_data.reps);
              end
            end
            MODE_CLEAR: begin
              load_out   = 1'b1;
              res.status = STAT_OK;
              used_nxt   = '0;
              total_nxt  = '0;
            end
            default: begin
              state_nxt = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (tail.valid) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
          if (!tail.found) begin
            res.status = STAT_MISSING;
          end else if (mode_r == MODE_FIND) begin
            res.status     = STAT_OK;
            res.slot       = idx_to_slot(tail.hit_idx);
            res.found_reps = tail.hit_reps;
          end else begin
            // swap the last entry into the hole; a self-copy is harmless
            res.status = STAT_OK;
            wr.en      = 1'b1;
            wr.idx     = tail.hit_idx;
            wr.key     = tail.last_key;
            wr.reps    = tail.last_reps;
            used_nxt   = last_idx;
            total_nxt  = total_r - TOTAL_W'(tail.hit_reps);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    res.entry_count = cnt_to_ecount(used_nxt);
    res.total_reps  = total_nxt[TREPS_W-1:0];

    // hold while stalled, drop once taken
    out_valid_nxt = load_out || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mode_r <= in_data.mode;
    end
    if (load_out) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DEPTH_CNT)
    else $error("entry count beyond table depth");

  a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> (state_r == ST_SCAN))
    else $error("search token left the row outside a scan");

  a_hit_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (tail.valid && tail.found) |-> (used_r != '0))
    else $error("match reported on an empty table");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_accept || tail.valid))
    else $error("result appeared without a transfer or a finished scan");
`endif

endmodule

>>> hw/rtl/ktsr_cell.sv
// ----------------------------------------------------------------------------
// ktsr_cell: one table slot of the cell row
// Stores one key and count, checks the passing search token against them,
// and hands the token on to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module ktsr_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [ktsr_pkg::IDX_W-1:0] cell_idx,
  input  logic [ktsr_pkg::CNT_W-1:0] used,
  input  logic [ktsr_pkg::CNT_W-1:0] last,
  input  ktsr_pkg::wr_t              wr,
  input  ktsr_pkg::tok_t             tok_in,
  output ktsr_pkg::tok_t             tok_out
);
  import ktsr_pkg::*;

  logic signed [KEY_W-1:0] key_r;
  logic [REPS_W-1:0]       reps_r;
  logic                    tok_valid_r;
  tok_t                    tok_r;
  tok_t                    tok_nxt;
  logic [CNT_W-1:0]        idx_ext;
  logic                    in_use;

  assign idx_ext = idx_to_cnt(cell_idx);
  assign in_use  = (idx_ext < used);

  always_comb begin
    tok_nxt = tok_in;
    // take the first match only
    if (in_use && !tok_in.found && (key_r == tok_in.key)) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.hit_idx  = cell_idx;
      tok_nxt.hit_reps = reps_r;
    end
    if (idx_ext == last) begin
      tok_nxt.last_key  = key_r;
      tok_nxt.last_reps = reps_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else begin
      tok_valid_r <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (wr.en && (wr.idx == cell_idx)) begin
      key_r  <= wr.key;
      reps_r <= wr.reps;
    end
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = tok_valid_r;
  end

endmodule

>>> sim/keyed_table_swap_remove_unit_tb.sv
// ----------------------------------------------------------------------------
// keyed_table_swap_remove_unit_tb: self-checking bench for the keyed table
// Drives add, find, remove and clear operations through the valid/stall input
// channel and keeps a shadow copy of the table. Every accepted operation is
// applied to the shadow copy, and the outcome is queued. Each result transfer
// is checked field by field against the oldest queued outcome. Random idle
// cycles are inserted on both sides. One long receiver hold fills the unit.
// ----------------------------------------------------------------------------
module keyed_table_swap_remove_unit_tb;
  import ktsr_pkg::*;

  localparam int CYCLE_LIMIT  = 400_000;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 700;
  localparam int POOL_SIZE    = 12;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  ktsr_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  ktsr_out_t out_data;

  // Shadow copy of the table; slots at or above shadow_used are never read.
  logic [KEY_W-1:0]   shadow_keys   [TABLE_DEPTH];
  logic [REPS_W-1:0]  shadow_counts [TABLE_DEPTH];
  int unsigned        shadow_used = 0;
  logic [TOTAL_W-1:0] shadow_total = '0;

  ktsr_out_t pending_results[$];

  // Key pool: small, so that finds and removes hit and duplicates pile up.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int  errors = 0;
  int  ops_sent = 0;
  int  results_checked = 0;
  int  cycle_count = 0;
  int  n_add = 0, n_full = 0, n_find = 0, n_remove = 0, n_clear = 0;
  int  n_missing = 0, peak_used = 0;
  bit  calm = 1'b0;       // no idling on either side while set
  int  hold_requests = 0; // bumped by the test to ask for one long receiver hold

  keyed_table_swap_remove_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drop the run if it stalls for far longer than the slowest correct run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ------------------------------------------------------------------
  // Shadow table
  // ------------------------------------------------------------------

  // Return the lowest used slot that holds key k, or -1 if none does.
  function automatic int lowest_match(input logic [KEY_W-1:0] k);
    for (int i = 0; i < int'(shadow_used); i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return -1;
  endfunction

  // Apply one operation to the shadow table and return the result it gives.
  function automatic ktsr_out_t apply_to_shadow(input ktsr_in_t op);
    ktsr_out_t res;
    int        hit;
    int        last;
    res = '0;
    res.status = STAT_OK;
    case (op.mode)
      MODE_ADD: begin
        n_add++;
        if (shadow_used >= TABLE_DEPTH) begin
          res.status = STAT_FULL;
          n_full++;
        end else begin
          res.slot = SLOT_W'(shadow_used);
          shadow_keys[shadow_used]   = op.key;
          shadow_counts[shadow_used] = op.reps;
          shadow_used++;
          shadow_total = shadow_total + TOTAL_W'(op.reps);
        end
      end
      MODE_FIND: begin
        n_find++;
        hit = lowest_match(op.key);
        if (hit < 0) begin
          res.status = STAT_MISSING;
          n_missing++;
        end else begin
          res.slot       = SLOT_W'(hit);
          res.found_reps = shadow_counts[hit];
        end
      end
      MODE_REMOVE: begin
        n_remove++;
        hit = lowest_match(op.key);
        if (hit < 0) begin
          res.status = STAT_MISSING;
          n_missing++;
        end else begin
          // Swap the last entry into the hole; a hit on the last slot just drops it.
          last = int'(shadow_used) - 1;
          shadow_total       = shadow_total - TOTAL_W'(shadow_counts[hit]);
          shadow_keys[hit]   = shadow_keys[last];
          shadow_counts[hit] = shadow_counts[last];
          shadow_used        = last;
        end
      end
      default: begin
        n_clear++;
        shadow_used  = 0;
        shadow_total = '0;
      end
    endcase
    if (int'(shadow_used) > peak_used) peak_used = shadow_used;
    res.entry_count = ECOUNT_W'(shadow_used);
    res.total_reps  = shadow_total[TREPS_W-1:0];
    return res;
  endfunction

  // ------------------------------------------------------------------
  // Receiver: check each result transfer, then pick the next stall value
  // ------------------------------------------------------------------
  int hold_seen = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    ktsr_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing pending: %p", out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            errors++;
          end
          if (out_data.slot !== want.slot) begin
            $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
            errors++;
          end
          if (out_data.found_reps !== want.found_reps) begin
            $error("found_reps: expected %0d, got %0d", want.found_reps,
                   out_data.found_reps);
            errors++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count,
                   out_data.entry_count);
            errors++;
          end
          if (out_data.total_reps !== want.total_reps) begin
            $error("total_reps: expected %0d, got %0d", want.total_reps,
                   out_data.total_reps);
            errors++;
          end
        end
      end
      // Start a long hold when the test asks for one; count it down here.
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 30);
      end
    end
  end

  // ------------------------------------------------------------------
  // Sender
  // ------------------------------------------------------------------

  function automatic ktsr_in_t make_op(input mode_t m, input logic [KEY_W-1:0] k,
                                       input logic [REPS_W-1:0] r);
    ktsr_in_t op;
    op.mode = m;
    op.key  = k;
    op.reps = r;
    return op;
  endfunction

  // Offer one operation and return at the edge that takes it. Valid stays high
  // afterwards, so the caller must not let time pass before the next call.
  task automatic send_op(input ktsr_in_t op);
    while (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data  <= op;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(apply_to_shadow(op));
    ops_sent++;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic ktsr_in_t random_op();
    int    roll;
    mode_t m;
    roll = $urandom_range(0, 99);
    if (roll < 2)       m = MODE_CLEAR;
    else if (roll < 45) m = MODE_ADD;
    else if (roll < 72) m = MODE_FIND;
    else                m = MODE_REMOVE;
    return make_op(m, pick_key(), REPS_W'($urandom()));
  endfunction

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // Clear, find and remove on a table that has never held anything.
  task automatic test_empty_table();
    send_op(make_op(MODE_CLEAR,  32'h0000_0000, 16'h0000));
    send_op(make_op(MODE_FIND,   32'h0000_0000, 16'hFFFF));
    send_op(make_op(MODE_REMOVE, 32'h0000_0000, 16'h0000));
  endtask

  // Extreme keys and counts, a duplicate key, lowest-slot hits and a miss.
  task automatic test_add_find_extremes();
    send_op(make_op(MODE_ADD,  32'h8000_0000, 16'hFFFF));
    send_op(make_op(MODE_ADD,  32'h7FFF_FFFF, 16'h0000));
    send_op(make_op(MODE_ADD,  32'hFFFF_FFFF, 16'h0001));
    send_op(make_op(MODE_ADD,  32'h0000_0000, 16'h8000));
    send_op(make_op(MODE_ADD,  32'h8000_0000, 16'h1234));
    send_op(make_op(MODE_FIND, 32'h8000_0000, 16'h0000));
    send_op(make_op(MODE_FIND, 32'hFFFF_FFFF, 16'h0000));
    send_op(make_op(MODE_FIND, 32'h1234_5678, 16'h0000));
  endtask

  // Remove at the front (swap in the duplicate), at the end, in the middle,
  // and a remove that misses.
  task automatic test_remove_cases();
    send_op(make_op(MODE_REMOVE, 32'h8000_0000, 16'h0000));
    send_op(make_op(MODE_FIND,   32'h8000_0000, 16'h0000));
    send_op(make_op(MODE_REMOVE, 32'h0000_0000, 16'h0000));
    send_op(make_op(MODE_REMOVE, 32'h7FFF_FFFF, 16'h0000));
    send_op(make_op(MODE_REMOVE, 32'h5555_5555, 16'h0000));
    send_op(make_op(MODE_FIND,   32'hFFFF_FFFF, 16'h0000));
  endtask

  // Clear must hide the stale entries; then drain a two-entry table to empty.
  task automatic test_clear_hides_stale();
    send_op(make_op(MODE_CLEAR,  32'hFFFF_FFFF, 16'hFFFF));
    send_op(make_op(MODE_FIND,   32'hFFFF_FFFF, 16'h0000));
    send_op(make_op(MODE_ADD,    32'h2AAA_AAAA, 16'hAAAA));
    send_op(make_op(MODE_ADD,    32'h5555_5555, 16'h5555));
    send_op(make_op(MODE_REMOVE, 32'h2AAA_AAAA, 16'h0000));
    send_op(make_op(MODE_REMOVE, 32'h5555_5555, 16'h0000));
  endtask

  // Fill every slot with the largest count, overflow it, work on the full
  // table and refill the freed slot.
  task automatic test_fill_to_capacity();
    logic [KEY_W-1:0] top_key;
    send_op(make_op(MODE_CLEAR, 32'h0, 16'h0));
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      top_key = pick_key();
      send_op(make_op(MODE_ADD, top_key, 16'hFFFF));
    end
    send_op(make_op(MODE_ADD,  pick_key(), REPS_W'($urandom())));
    send_op(make_op(MODE_ADD,  pick_key(), REPS_W'($urandom())));
    send_op(make_op(MODE_FIND, top_key, 16'h0));
    for (int i = 0; i < 8; i++) send_op(make_op(MODE_FIND, pick_key(), 16'h0));
    send_op(make_op(MODE_REMOVE, shadow_keys[0], 16'h0));
    send_op(make_op(MODE_ADD,    32'hDEAD_BEEF, 16'hFFFF));
    send_op(make_op(MODE_ADD,    32'hDEAD_BEEF, 16'hFFFF));
    for (int i = 0; i < 6; i++) send_op(make_op(MODE_REMOVE, pick_key(), 16'h0));
    send_op(make_op(MODE_CLEAR, 32'h0, 16'h0));
  endtask

  // Hold the receiver off for a long stretch while items keep coming, so the
  // output register fills and the input stalls.
  task automatic test_backpressure();
    hold_requests++;
    for (int i = 0; i < 24; i++) send_op(random_op());
  endtask

  // Rounds of an add burst followed by mixed traffic; one calm stretch.
  task automatic test_random_traffic();
    int round_no;
    round_no = 0;
    while (ops_sent < RANDOM_ITEMS) begin
      calm = (round_no >= 6 && round_no < 10);
      repeat ($urandom_range(0, 40)) begin
        send_op(make_op(MODE_ADD, pick_key(), REPS_W'($urandom())));
      end
      repeat (20) send_op(random_op());
      round_no++;
    end
    calm = 1'b0;
  endtask

  // ------------------------------------------------------------------
  // Main sequence
  // ------------------------------------------------------------------
  initial begin
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_add_find_extremes();
    test_remove_cases();
    test_clear_hides_stale();
    test_fill_to_capacity();
    test_backpressure();
    test_random_traffic();

    // Drop valid, wait for every result, then a search's worth of settling.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("ran %0d ops: %0d adds (%0d rejected full), %0d finds, %0d removes, %0d clears",
             ops_sent, n_add, n_full, n_find, n_remove, n_clear);
    $display("%0d lookups missed, peak occupancy %0d of %0d, %0d results checked, %0d errors",
             n_missing, peak_used, TABLE_DEPTH, results_checked, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
